// ===== src/cache_tag_lookup_write_back_assert.svh =====
// Assertion macros for the cache tag controller.
`ifndef CACHE_TAG_LOOKUP_WRITE_BACK_ASSERT_SVH
`define CACHE_TAG_LOOKUP_WRITE_BACK_ASSERT_SVH
`ifndef SYNTH
`define CTL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CTL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/ctlwb_pkg.sv =====
// Shared types and constants of the cache tag controller.
package ctlwb_pkg;
    localparam int LINES_DEF     = 64;
    localparam int ADDR_BITS_DEF = 32;
    localparam int TAG_W         = 29;
    localparam int TAG_MAX       = 29;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_STORE = 2'd1;
    localparam logic [1:0] ACT_BLANK = 2'd2;

    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_FULL   = 2'd1;
    localparam logic [1:0] MODE_SET    = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_OFFSET = 3'd1;
    localparam logic [2:0] REG_INDEX  = 3'd2;
    localparam logic [2:0] REG_WAYS   = 3'd3;
    localparam logic [2:0] REG_LINES  = 3'd4;
    localparam logic [2:0] REG_TAG    = 3'd5;
    localparam logic [2:0] REG_SEED   = 3'd6;

    localparam logic [15:0] LFSR_MASK = 16'hB400;

    typedef struct packed {
        logic lookup;   // latch item and search
        logic update;   // commit tag store and counters
        logic emit;     // load output register
    } t_cmd;
endpackage

// ===== src/ctlwb_ctrl.sv =====
// Controller state machine of the cache tag controller.
module ctlwb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_out_free,
    output ctlwb_pkg::t_cmd   o_cmd
);
    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_UPD  = 1'b1;

    logic [0:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.lookup = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_UPD: begin
                // wait for the output register to be free, then commit
                if (i_out_free) begin
                    o_cmd.update = 1'b1;
                    o_cmd.emit   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== src/ctlwb_dp.sv =====
// Datapath: tag registers, parallel compare, victim choice and counters.
module ctlwb_dp #(
    parameter int LINES     = ctlwb_pkg::LINES_DEF,
    parameter int ADDR_BITS = ctlwb_pkg::ADDR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ctlwb_pkg::t_cmd        i_cmd,
    input  logic [1:0]             i_action,
    input  logic [31:0]            i_address,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    output logic                   o_valid,
    input  logic                   i_out_stall,
    output logic                   o_out_free,
    output logic                   o_hit,
    output logic [5:0]             o_line,
    output logic                   o_dirty_eviction,
    output logic [31:0]            o_access_count,
    output logic [31:0]            o_load_count,
    output logic [31:0]            o_store_count,
    output logic [31:0]            o_hit_count,
    output logic [31:0]            o_load_hit_count,
    output logic [31:0]            o_store_hit_count,
    output logic [31:0]            o_blank_count
);
    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int TW = ctlwb_pkg::TAG_W;

    logic [1:0]  r_mode;
    logic [4:0]  r_off;
    logic [2:0]  r_idx_bits, r_ways, r_lines;
    logic [4:0]  r_tbits;
    logic [15:0] r_lfsr;

    logic [TW-1:0]    r_tag [LINES];
    logic [LINES-1:0] r_valid, r_dirty;

    logic [1:0]  r_act;
    logic [31:0] r_addr;

    logic [31:0] r_acc, r_ld, r_st, r_hc, r_lh, r_sh, r_bl;

    logic        r_ovalid;

    // Lookup from the latched item (combinational compare).
    logic [ADDR_BITS-1:0] addr;
    logic [4:0]           tb;
    logic [TW-1:0]        tag;
    logic [31:0]          idx, base, size;
    logic [ADDR_BITS-1:0] sh_off;
    logic                 is_direct, is_mem;
    logic [LINES-1:0]     in_grp, match, free;
    logic                 found, free_found;
    logic [LW-1:0]        hit_l, free_l, vic_l, fin_l;
    logic [15:0]          lfsr_nx;
    logic [47:0]          prod;
    logic                 evict;

    always_comb begin
        addr = r_addr[ADDR_BITS-1:0];
        tb   = r_tbits;
        if (tb > 5'(ctlwb_pkg::TAG_MAX)) tb = 5'(ctlwb_pkg::TAG_MAX);
        if (32'(tb) > 32'(ADDR_BITS)) tb = 5'(ADDR_BITS);
        tag = (tb == 5'd0) ? '0 : TW'(addr >> (ADDR_BITS - int'(tb)));
        sh_off = addr >> r_off;
        idx = 32'(sh_off) & ((32'd1 << r_idx_bits) - 32'd1);
        is_direct = (r_mode != ctlwb_pkg::MODE_FULL) && (r_mode != ctlwb_pkg::MODE_SET);
        if (r_mode == ctlwb_pkg::MODE_FULL) begin
            base = '0;
            size = 32'd1 << r_lines;
        end else if (r_mode == ctlwb_pkg::MODE_SET) begin
            size = 32'd1 << r_ways;
            if (size > 32'(LINES)) size = 32'(LINES);
            base = idx << r_ways;
            if ((32'd1 << r_ways) > 32'(LINES)) base = idx * 32'(LINES);
        end else begin
            base = idx;
            size = 32'd1;
        end
        if (size > 32'(LINES)) size = 32'(LINES);
        is_mem = (r_act == ctlwb_pkg::ACT_LOAD) || (r_act == ctlwb_pkg::ACT_STORE);
    end

    // group membership per line: (l - base) mod LINES < size
    always_comb begin
        for (int l = 0; l < LINES; l++) begin
            logic [31:0] d;
            d = (32'(l) + 32'(LINES) - (base % 32'(LINES))) % 32'(LINES);
            in_grp[l] = d < size;
            match[l]  = in_grp[l] && r_valid[l] && (r_tag[l] == tag);
            free[l]   = in_grp[l] && !r_valid[l];
        end
    end

    // lowest in group order = first after base, with wrap
    always_comb begin
        logic [31:0] bm;
        logic [31:0] j;
        found = 1'b0; free_found = 1'b0;
        hit_l = '0; free_l = '0;
        bm = base % 32'(LINES);
        for (int w = 0; w < LINES; w++) begin
            j = (bm + 32'(w)) % 32'(LINES);
            if (!found && match[j[LW-1:0]]) begin
                found = 1'b1; hit_l = j[LW-1:0];
            end
            if (!free_found && free[j[LW-1:0]]) begin
                free_found = 1'b1; free_l = j[LW-1:0];
            end
        end
    end

    always_comb begin
        logic [31:0] way;
        lfsr_nx = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? ctlwb_pkg::LFSR_MASK : 16'd0);
        prod    = 48'(lfsr_nx) * 48'(size);
        way     = is_direct ? 32'd0 : 32'(prod >> 16);
        vic_l   = LW'((base + way) % 32'(LINES));
        if (found)           fin_l = hit_l;
        else if (free_found) fin_l = free_l;
        else                 fin_l = vic_l;
        evict = is_mem && !found && !free_found && r_dirty[vic_l];
    end

    assign o_out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_act  <= i_action;
            r_addr <= i_address;
        end
        if (i_cmd.update && is_mem && !found) r_tag[fin_l] <= tag;
        if (i_cmd.emit) begin
            o_hit            <= is_mem && found;
            o_line           <= is_mem ? 6'(fin_l) : 6'd0;
            o_dirty_eviction <= evict;
        end
    end

    assign o_access_count    = r_acc;
    assign o_load_count      = r_ld;
    assign o_store_count     = r_st;
    assign o_hit_count       = r_hc;
    assign o_load_hit_count  = r_lh;
    assign o_store_hit_count = r_sh;
    assign o_blank_count     = r_bl;
    assign o_valid           = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ctlwb_pkg::MODE_DIRECT; r_off <= '0; r_idx_bits <= '0;
            r_ways <= '0; r_lines <= 3'd6; r_tbits <= 5'd26; r_lfsr <= 16'd1;
            r_valid <= '0; r_dirty <= '0; r_ovalid <= 1'b0;
            r_acc <= '0; r_ld <= '0; r_st <= '0; r_hc <= '0;
            r_lh <= '0; r_sh <= '0; r_bl <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ctlwb_pkg::REG_MODE:   r_mode     <= i_cfg_data[1:0];
                    ctlwb_pkg::REG_OFFSET: r_off      <= i_cfg_data[4:0];
                    ctlwb_pkg::REG_INDEX:  r_idx_bits <= i_cfg_data[2:0];
                    ctlwb_pkg::REG_WAYS:   r_ways     <= i_cfg_data[2:0];
                    ctlwb_pkg::REG_LINES:  r_lines    <= i_cfg_data[2:0];
                    ctlwb_pkg::REG_TAG:    r_tbits    <= i_cfg_data[4:0];
                    ctlwb_pkg::REG_SEED:
                        r_lfsr <= (i_cfg_data[15:0] == 16'd0) ? 16'd1 : i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.emit) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
            if (i_cmd.update) begin
                if (is_mem) begin
                    r_acc <= r_acc + 32'd1;
                    if (found) r_hc <= r_hc + 32'd1;
                    if (!found) r_valid[fin_l] <= 1'b1;
                    if (!found && !free_found && !is_direct) r_lfsr <= lfsr_nx;
                    if (r_act == ctlwb_pkg::ACT_LOAD) begin
                        r_ld <= r_ld + 32'd1;
                        if (found) r_lh <= r_lh + 32'd1;
                        if (evict) r_dirty[fin_l] <= 1'b0;
                    end else begin
                        r_st <= r_st + 32'd1;
                        if (found) r_sh <= r_sh + 32'd1;
                        r_dirty[fin_l] <= 1'b1;
                    end
                end else if (r_act == ctlwb_pkg::ACT_BLANK) begin
                    r_bl <= r_bl + 32'd1;
                end
            end
        end
    end
endmodule

// ===== src/cache_tag_lookup_write_back.sv =====
// The accepting edge latches the item; compare and commit follow in the update state,
// which loads the output register; a stalled result holds back commit and the next item.
// A new item is taken only after the last is committed; tags sit in registers and all
// lines are compared in parallel, then the update step writes tags, marks and counters.
// Reset: synchronous active low; clears valid and dirty marks and counters, restores
// config defaults, loads the victim LFSR with 1. Tag registers are not cleared.
`include "cache_tag_lookup_write_back_assert.svh"
module cache_tag_lookup_write_back #(
    parameter int LINES     = ctlwb_pkg::LINES_DEF,
    parameter int ADDR_BITS = ctlwb_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_address,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [5:0]  o_line,
    output logic        o_dirty_eviction,
    output logic [31:0] o_access_count,
    output logic [31:0] o_load_count,
    output logic [31:0] o_store_count,
    output logic [31:0] o_hit_count,
    output logic [31:0] o_load_hit_count,
    output logic [31:0] o_store_hit_count,
    output logic [31:0] o_blank_count
);
    ctlwb_pkg::t_cmd cmd;
    logic            out_free;

    assign o_cfg_ready = 1'b1;

    ctlwb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_out_free (out_free),
        .o_cmd      (cmd)
    );

    ctlwb_dp #(.LINES(LINES), .ADDR_BITS(ADDR_BITS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_action          (i_action),
        .i_address         (i_address),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_out_stall       (i_stall),
        .o_out_free        (out_free),
        .o_hit             (o_hit),
        .o_line            (o_line),
        .o_dirty_eviction  (o_dirty_eviction),
        .o_access_count    (o_access_count),
        .o_load_count      (o_load_count),
        .o_store_count     (o_store_count),
        .o_hit_count       (o_hit_count),
        .o_load_hit_count  (o_load_hit_count),
        .o_store_hit_count (o_store_hit_count),
        .o_blank_count     (o_blank_count)
    );

    `CTL_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, cmd.lookup, !cmd.update)
    `CTL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `CTL_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, cmd.emit, o_valid)
    `CTL_ASSERT_IMPL(a_hit_no_evict, i_clk, i_rst_n, o_valid && o_hit, !o_dirty_eviction)
endmodule
